### hw/rtl/dqlp_pkg.sv
// Package for the DNS question-name label parser.
// Holds the transaction types, status codes and constants shared by all modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dqlp_pkg;

  localparam int DQLP_MAX_NAME = 256;
  localparam int CAP_W         = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [1:0] PTR_MARK = 2'b11;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_COMPRESS = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] data_length;
    logic        start_req;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] name_length;
    status_t    status;
    logic       done_res;
    logic [7:0] out_char;
    logic       char_valid;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/dqlp_in_reg.sv
// Input register stage of the DNS question-name label parser.
// Captures one input transaction and holds it until the decoder consumes it.
// Depends on dqlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqlp_in_reg
  import dqlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,
  input  wire logic [0:0]  s_tuser,
  input  wire logic        advance,
  output logic             item_valid,
  output in_item_t         item
);

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data_byte   <= s_tdata[7:0];
      item.data_length <= s_tdata[23:8];
      item.start_req   <= s_tuser[0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dqlp_core.sv
// Label decoder of the DNS question-name label parser.
// Holds the parse state and the capacity register and decodes one byte per cycle unless a held result stalls it.
// Depends on dqlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqlp_core
  import dqlp_pkg::*;
#(
  parameter int MAX_NAME = DQLP_MAX_NAME
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire logic             item_valid,
  input  wire in_item_t         item,
  input  wire logic             out_free,
  output logic                  advance,
  output logic                  res_valid,
  output out_item_t             res
);

  localparam int NPW = $clog2(MAX_NAME + 1);
  localparam int SW  = ((NPW > CAP_W) ? NPW : CAP_W) + 2;
  localparam int BW  = 17;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_LEN   = 3'b010,
    PH_LABEL = 3'b100
  } phase_t;

  logic [CAP_W-1:0] name_capacity;
  phase_t           phase, phase_next, phase_eff;
  logic [7:0]       label_remaining, label_remaining_next, label_remaining_eff;
  logic [NPW-1:0]   name_position, name_position_next, name_position_eff;
  logic [15:0]      byte_position, byte_position_next, byte_position_eff;
  logic [15:0]      saved_length, saved_length_next, saved_length_eff;
  logic             first_label, first_label_next, first_label_eff;

  logic [SW-1:0]    cap;
  logic [SW-1:0]    np_ext;
  logic [SW-1:0]    np_inc;
  logic [SW-1:0]    np_need;
  logic [BW-1:0]    bp_inc;
  logic [BW-1:0]    bp_need;
  logic [SW-1:0]    len_ext;
  logic             has_result;
  logic             char_valid;
  logic [7:0]       out_char;
  logic             done_res;
  status_t          status;

  always_comb begin
    if (SW'(name_capacity) > SW'(MAX_NAME)) begin
      cap = SW'(MAX_NAME);
    end else begin
      cap = SW'(name_capacity);
    end
  end

  always_comb begin
    if (item.start_req) begin
      phase_eff           = PH_LEN;
      label_remaining_eff = '0;
      name_position_eff   = '0;
      byte_position_eff   = '0;
      saved_length_eff    = item.data_length;
      first_label_eff     = 1'b1;
    end else begin
      phase_eff           = phase;
      label_remaining_eff = label_remaining;
      name_position_eff   = name_position;
      byte_position_eff   = byte_position;
      saved_length_eff    = saved_length;
      first_label_eff     = first_label;
    end

    np_ext  = SW'(name_position_eff);
    np_inc  = np_ext + SW'(1);
    np_need = np_ext + SW'(item.data_byte) + SW'(1);
    bp_inc  = BW'(byte_position_eff) + BW'(1);
    bp_need = bp_inc + BW'(item.data_byte);

    phase_next           = phase_eff;
    label_remaining_next = label_remaining_eff;
    name_position_next   = name_position_eff;
    byte_position_next   = byte_position_eff;
    saved_length_next    = saved_length_eff;
    first_label_next     = first_label_eff;

    has_result = 1'b0;
    char_valid = 1'b0;
    out_char   = '0;
    done_res   = 1'b0;
    status     = ST_OK;

    if (item.start_req && (item.data_length == '0 || cap == '0)) begin
      has_result = 1'b1;
      done_res   = 1'b1;
      status     = ST_INVALID;
    end else if (item.start_req && cap == SW'(1)) begin
      has_result = 1'b1;
      done_res   = 1'b1;
    end else begin
      unique case (phase_eff)
        PH_LEN: begin
          byte_position_next = bp_inc[15:0];
          if (item.data_byte == '0) begin
            has_result = 1'b1;
            done_res   = 1'b1;
          end else if (item.data_byte[7:6] == PTR_MARK) begin
            has_result = 1'b1;
            done_res   = 1'b1;
            status     = ST_COMPRESS;
          end else if (bp_need > BW'(saved_length_eff) || np_need >= cap) begin
            has_result = 1'b1;
            done_res   = 1'b1;
            status     = ST_INVALID;
          end else begin
            label_remaining_next = item.data_byte;
            phase_next           = PH_LABEL;
            if (!first_label_eff) begin
              name_position_next = np_inc[NPW-1:0];
              has_result         = 1'b1;
              char_valid         = 1'b1;
              out_char           = CHAR_DOT;
            end else begin
              first_label_next = 1'b0;
            end
          end
        end
        PH_LABEL: begin
          byte_position_next = bp_inc[15:0];
          name_position_next = np_inc[NPW-1:0];
          has_result         = 1'b1;
          char_valid         = 1'b1;
          out_char           = item.data_byte;
          if (label_remaining_eff != '0) begin
            label_remaining_next = label_remaining_eff - 8'd1;
          end
          if (label_remaining_eff <= 8'd1) begin
            phase_next = PH_LEN;
            if (bp_inc >= BW'(saved_length_eff) || (np_inc + SW'(1)) >= cap) begin
              done_res = 1'b1;
            end
          end
        end
        PH_IDLE: begin
          has_result = 1'b0;
        end
        default: begin
          has_result = 1'b0;
        end
      endcase
    end

    if (done_res) begin
      phase_next = PH_IDLE;
    end
  end

  assign len_ext   = SW'(name_position_next);
  assign advance   = item_valid && (out_free || !has_result);
  assign res_valid = advance && has_result;

  always_comb begin
    res.char_valid  = char_valid;
    res.out_char    = out_char;
    res.done_res    = done_res;
    res.status      = status;
    res.name_length = '0;
    if (done_res && status == ST_OK) begin
      if (len_ext > SW'(255)) begin
        res.name_length = 8'd255;
      end else begin
        res.name_length = len_ext[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_capacity <= CAP_RESET;
    end else if (cfg_wen) begin
      name_capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      label_remaining <= '0;
      name_position   <= '0;
      byte_position   <= '0;
      saved_length    <= '0;
      first_label     <= 1'b1;
    end else if (advance) begin
      phase           <= phase_next;
      label_remaining <= label_remaining_next;
      name_position   <= name_position_next;
      byte_position   <= byte_position_next;
      saved_length    <= saved_length_next;
      first_label     <= first_label_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dqlp_out_reg.sv
// Output register stage of the DNS question-name label parser.
// Holds one result transaction until the downstream side takes it.
// Depends on dqlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqlp_out_reg
  import dqlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire out_item_t   res,
  output logic             out_free,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tlast,
  output logic [2:0]       m_tuser
);

  out_item_t held;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {held.name_length, held.out_char};
  assign m_tlast = held.done_res;
  assign m_tuser = {held.status, held.char_valid};

endmodule

`default_nettype wire

### hw/rtl/dns_qname_label_parser_top.sv
// Top level of the DNS question-name label parser.
// Instantiates dqlp_in_reg, dqlp_core and dqlp_out_reg; depends on dqlp_pkg.
//
// Channel   Dir  Signals                      Contents (lowest bit first)
// s_*       in   tvalid tready tdata tuser    tdata: data_byte, data_length; tuser: start_req
// m_*       out  tvalid tready tdata tlast    tdata: out_char, name_length; tlast: done_res
//                tuser                        tuser: char_valid, status
// cfg_*     in   wen wdata                    wdata: name_capacity
//
// One byte is decoded per cycle unless a held result stalls it; its result is shown on m_* from the output register.
// The input register feeds the decoder, which writes the output register in one pass.
// Reset clears the parse state to idle and sets the capacity register to 256.
// A held result stalls only bytes that produce a result; others drain through.
`timescale 1ns / 1ps
`default_nettype none

module dns_qname_label_parser_top
  import dqlp_pkg::*;
#(
  parameter int MAX_NAME = DQLP_MAX_NAME
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [23:0]      s_tdata,   // data_byte, data_length
  input  wire logic [0:0]       s_tuser,   // start_req
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [15:0]           m_tdata,   // out_char, name_length
  output logic                  m_tlast,
  output logic [2:0]            m_tuser,   // char_valid, status
  input  wire logic             cfg_wen,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  logic      advance;
  logic      item_valid;
  in_item_t  item;
  logic      out_free;
  logic      res_valid;
  out_item_t res;

  dqlp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dqlp_core #(
    .MAX_NAME (MAX_NAME)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  dqlp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

### hw/rtl/dqlp_checker.sv
// Port-level checker for the DNS question-name label parser, with its bind.
// Watches the top-level ports only; depends on dqlp_pkg and dns_qname_label_parser_top.
`timescale 1ns / 1ps
`default_nettype none

module dqlp_checker
  import dqlp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic [2:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("Stalled result transaction changed.");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] != ST_OK |-> m_tlast && !m_tuser[0])
    else $error("Error status on a result that does not end the name.");

  a_length_on_ok_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15:8] != 8'd0 |-> m_tlast && m_tuser[2:1] == ST_OK)
    else $error("Name length shown outside a successful end of name.");

  a_char_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:0] != 8'd0 |-> m_tuser[0])
    else $error("Character byte set without its valid flag.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[2:1] == ST_OK || m_tuser[2:1] == ST_INVALID
      || m_tuser[2:1] == ST_COMPRESS))
    else $error("Undefined status code.");

endmodule

bind dns_qname_label_parser_top dqlp_checker u_dqlp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for dns_qname_label_parser_top: decodes each accepted byte with its
// own label decoder and compares every output transaction, with bursty input and a stalling
// receiver. Depends on dqlp_pkg and the RTL of the parser.
`timescale 1ns / 1ps

module testbench;
  import dqlp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;

  typedef logic [7:0] byte_q_t[$];
  typedef enum logic [1:0] {PARSE_IDLE, PARSE_LEN, PARSE_LABEL} parse_phase_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;
  logic [0:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;
  logic              m_tlast;
  logic [2:0]        m_tuser;
  logic              cfg_wen = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = CAP_RESET;

  dns_qname_label_parser_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Decoder state, mirrored from the block.
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;
  parse_phase_t     parse_phase  = PARSE_IDLE;
  int unsigned      label_left   = 0;
  int unsigned      name_chars   = 0;
  int unsigned      byte_pos     = 0;
  int unsigned      saved_len    = 0;
  bit               first_label  = 1'b1;

  out_item_t   predicted_outputs[$];
  int unsigned bytes_sent = 0;
  int unsigned outputs_checked = 0;
  int unsigned mismatches = 0;
  int unsigned capacity_writes = 0;
  int unsigned names_ok = 0;
  int unsigned names_invalid = 0;
  int unsigned names_compress = 0;

  bit          steady_sender = 1'b0;
  int unsigned burst_left = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  logic [1:0]  rx_phase = '0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned idle_cycles = 0;

  function automatic void post_output(bit cv, logic [7:0] ch, bit done, status_t st);
    out_item_t o;
    o.char_valid  = cv;
    o.out_char    = cv ? ch : 8'd0;
    o.done_res    = done;
    o.status      = done ? st : ST_OK;
    o.name_length = (done && st == ST_OK) ?
                    ((name_chars > 255) ? 8'd255 : 8'(name_chars)) : 8'd0;
    predicted_outputs.push_back(o);
    if (done) parse_phase = PARSE_IDLE;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic start, logic [15:0] avail);
    int unsigned cap;
    cap = (capacity_reg > DQLP_MAX_NAME) ? DQLP_MAX_NAME : capacity_reg;
    if (start) begin
      saved_len   = avail;
      byte_pos    = 0;
      name_chars  = 0;
      label_left  = 0;
      first_label = 1'b1;
      parse_phase = PARSE_LEN;
      if (saved_len == 0 || cap == 0) begin
        post_output(1'b0, 8'd0, 1'b1, ST_INVALID);
        return;
      end
      if (cap == 1) begin
        post_output(1'b0, 8'd0, 1'b1, ST_OK);
        return;
      end
    end
    if (parse_phase == PARSE_LEN) begin
      byte_pos++;
      if (b == 8'd0) begin
        post_output(1'b0, 8'd0, 1'b1, ST_OK);
      end else if (b[7:6] == PTR_MARK) begin
        post_output(1'b0, 8'd0, 1'b1, ST_COMPRESS);
      end else if (byte_pos + b > saved_len || name_chars + b + 1 >= cap) begin
        post_output(1'b0, 8'd0, 1'b1, ST_INVALID);
      end else begin
        label_left  = b;
        parse_phase = PARSE_LABEL;
        if (!first_label) begin
          name_chars++;
          post_output(1'b1, CHAR_DOT, 1'b0, ST_OK);
        end else begin
          first_label = 1'b0;
        end
      end
    end else if (parse_phase == PARSE_LABEL) begin
      byte_pos++;
      name_chars++;
      if (label_left > 0) label_left--;
      if (label_left == 0) begin
        parse_phase = PARSE_LEN;
        post_output(1'b1, b, byte_pos >= saved_len || name_chars + 1 >= cap, ST_OK);
      end else begin
        post_output(1'b1, b, 1'b0, ST_OK);
      end
    end
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_outputs
    out_item_t seen;
    out_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.char_valid  = m_tuser[0];
      seen.status      = status_t'(m_tuser[2:1]);
      seen.done_res    = m_tlast;
      seen.out_char    = m_tdata[7:0];
      seen.name_length = m_tdata[15:8];
      if (predicted_outputs.size() == 0) begin
        $error("output transaction with nothing expected: char %0h done %0b status %0d",
               seen.out_char, seen.done_res, seen.status);
        mismatches++;
      end else begin
        want = predicted_outputs.pop_front();
        compare_field("char_valid", want.char_valid, seen.char_valid);
        compare_field("out_char", want.out_char, seen.out_char);
        compare_field("done_res", want.done_res, seen.done_res);
        compare_field("status", want.status, seen.status);
        compare_field("name_length", want.name_length, seen.name_length);
        outputs_checked++;
        if (want.done_res) begin
          case (want.status)
            ST_OK:      names_ok++;
            ST_INVALID: names_invalid++;
            default:    names_compress++;
          endcase
        end
      end
    end
  end

  // Receiver: changes its stall pattern now and then, and honors long hold-off requests.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:     m_tready <= 1'b1;
        RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: m_tready <= (rx_phase != 2'b11);
        default:     m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start, input logic [15:0] avail);
    int unsigned gap;
    if (!steady_sender) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {avail, b};
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    decode_byte(b, start, avail);
  endtask

  task automatic send_name(input byte_q_t seq, input logic [15:0] avail);
    foreach (seq[i]) begin
      if (i == 0) send_byte(seq[i], 1'b1, avail);
      else send_byte(seq[i], 1'b0, 16'($urandom));
    end
  endtask

  task automatic wait_until_idle();
    s_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_until_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    capacity_reg = value;
    capacity_writes++;
  endtask

  task automatic send_random_name(input int unsigned cap_now);
    byte_q_t     seq;
    logic [15:0] avail;
    int unsigned kind;
    int unsigned len_l;
    int unsigned ending;
    int unsigned cut;
    steady_sender = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 4) == 0,
                                               16'($urandom));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 15) == 0) len_l = $urandom_range(11, (cap_now > 150) ? 120 : 30);
      else len_l = $urandom_range(1, 10);
      seq.push_back(8'(len_l));
      repeat (len_l) seq.push_back(8'($urandom));
    end
    avail  = 16'(seq.size());
    ending = $urandom_range(0, 99);
    if (ending < 60) begin
      seq.push_back(8'd0);
      avail = 16'(seq.size() + $urandom_range(0, 2));
    end else if (ending >= 75 && ending < 87) begin
      seq.push_back(8'hC0 | 8'($urandom_range(0, 63)));
      avail = 16'(seq.size() + $urandom_range(0, 30));
    end else if (ending >= 87 && ending < 94) begin
      seq.push_back(8'd0);
      avail = 16'($urandom_range(1, seq.size() - 1));
    end else if (ending >= 94) begin
      // The name is cut short; the next start arrives while it is still being parsed.
      cut   = $urandom_range(0, seq.size() - 1);
      seq   = seq[0:cut];
      avail = 16'(seq.size() + $urandom_range(1, 40));
    end
    send_name(seq, avail);
  endtask

  task automatic test_directed_names();
    send_name('{8'd3, 8'h77, 8'h77, 8'h77, 8'd2, 8'h65, 8'h78, 8'd0}, 16'd8);
    send_name('{8'd2, 8'h61, 8'h62}, 16'd3);
    send_byte(8'h55, 1'b0, 16'hAAAA);
    send_name('{8'hC0}, 16'd10);
    send_name('{8'd1, 8'h61, 8'hFF}, 16'd3);
    send_name('{8'h7F}, 16'd5);
    send_name('{8'h40, 8'h00, 8'hFF}, 16'hFFFF);
    send_name('{8'd1, 8'h7A, 8'd0}, 16'd3);
    send_name('{8'd0}, 16'd0);
    send_name('{8'd5}, 16'd3);
    send_name('{8'd0}, 16'hFFFF);
  endtask

  task automatic test_capacity_corners();
    set_capacity(9'd0);
    send_name('{8'd1, 8'h61}, 16'd5);
    set_capacity(9'd1);
    send_name('{8'd1}, 16'd5);
    set_capacity(9'd2);
    send_name('{8'd1, 8'h61, 8'd0}, 16'd3);
    set_capacity(9'd4);
    send_name('{8'd1, 8'h61, 8'd1, 8'h62}, 16'd9);
    set_capacity(9'd511);
    send_name('{8'd3, 8'h61, 8'h62, 8'h63, 8'd0}, 16'd5);
  endtask

  task automatic test_random_names();
    logic [CAP_W-1:0] caps[6] = '{9'd256, 9'd48, 9'd511, 9'd9, 9'd130, 9'd3};
    int unsigned stop_at;
    foreach (caps[i]) begin
      set_capacity(caps[i]);
      stop_at = bytes_sent + 120;
      while (bytes_sent < stop_at) begin
        send_random_name((caps[i] > DQLP_MAX_NAME) ? DQLP_MAX_NAME : caps[i]);
      end
    end
  endtask

  task automatic test_receiver_holdoff();
    int unsigned stop_at;
    set_capacity(9'd256);
    hold_request = 400;
    stop_at = bytes_sent + 80;
    while (bytes_sent < stop_at) send_random_name(DQLP_MAX_NAME);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_names();
    test_capacity_corners();
    test_random_names();
    test_receiver_holdoff();
    wait_until_idle();
    $display("Sent %0d bytes and checked %0d output transactions over %0d capacity writes.",
             bytes_sent, outputs_checked, capacity_writes);
    $display("Names ended ok: %0d, invalid: %0d, compression pointer: %0d.",
             names_ok, names_invalid, names_compress);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
